>>> rtl/core/u8tw_pkg.sv
// shared constants for the utf-8 text width estimator
// no dependencies; used by the interfaces and the top level
`default_nettype none

package u8tw_pkg;

  // default limit on counted bytes per string
  localparam int unsigned DefaultMaxTextBytes = 4096;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SizeW   = 8;
  localparam int unsigned HeightW = 10;
  localparam int unsigned WidthW  = 21;
  localparam int unsigned PendW   = 3;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFontSizeSet    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFontSizeInFile = 1'b1;

  // reset values and offsets
  localparam logic [SizeW-1:0]   FontSizeReset = 8'd25;
  localparam logic [HeightW-1:0] HeightOffset  = 10'd25;

endpackage

`default_nettype wire

>>> rtl/core/u8tw_in_if.sv
// input item channel: one text byte or a terminator
// depends on u8tw_pkg
`default_nettype none

interface u8tw_in_if
  import u8tw_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> rtl/core/u8tw_out_if.sv
// result item channel: validity, width, height and overflow flag
// depends on u8tw_pkg
`default_nettype none

interface u8tw_out_if
  import u8tw_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      valid_utf8;
  logic signed [WidthW-1:0]  pixel_width;
  logic signed [HeightW-1:0] pixel_height;
  logic                      too_long;

  modport source (output valid, output valid_utf8, output pixel_width,
                  output pixel_height, output too_long, input ready);
  modport sink   (input valid, input valid_utf8, input pixel_width,
                  input pixel_height, input too_long, output ready);
endinterface

`default_nettype wire

>>> rtl/core/u8tw_cfg_if.sv
// configuration write channel: register index and write data
// depends on u8tw_pkg
`default_nettype none

interface u8tw_cfg_if
  import u8tw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] addr;
  logic [SizeW-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/utf8_text_width_estimator.sv
// A result is registered: it appears in the cycle after its terminator item is accepted.
// Throughput: one item per cycle; any item, byte or terminator, waits while the
// previous result is held in the output register and not taken.
// The per-byte check and both counters update in the accepting cycle; the
// width multiply sits between the state registers and the result register.
// Reset (rst_ni low, async): counters, string flags and output valid clear, both font sizes go to 25.
`default_nettype none

module utf8_text_width_estimator
  import u8tw_pkg::*;
#(
  parameter int unsigned MAX_TEXT_BYTES = DefaultMaxTextBytes
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  u8tw_in_if.sink     in_i,
  u8tw_cfg_if.sink    cfg_i,
  u8tw_out_if.source  out_o
);

  localparam int unsigned RawW   = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned GlyphW = $clog2(2 * MAX_TEXT_BYTES + 1);
  localparam int unsigned MulW   = HeightW + GlyphW + 1;
  localparam int unsigned ProdW  = (MulW > WidthW) ? MulW : WidthW;
  localparam logic [RawW-1:0] MaxCount = RawW'(MAX_TEXT_BYTES);

  // configuration registers
  logic [SizeW-1:0] size_set_q, size_file_q;

  // per-string state
  logic [PendW-1:0]  pend_q, pend_d;
  logic              bad_q, bad_d;
  logic [GlyphW-1:0] glyph_q, glyph_d;
  logic [RawW-1:0]   raw_q, raw_d;
  logic              sat_q, sat_d;

  // result register
  logic                      out_valid_q;
  logic                      res_utf8_q;
  logic signed [WidthW-1:0]  res_width_q;
  logic signed [HeightW-1:0] res_height_q;
  logic                      res_long_q;

  logic in_acc, byte_acc, term_acc, out_free;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = out_free;
  assign cfg_i.ready = 1'b1;
  assign in_acc   = in_i.valid && in_i.ready;
  assign byte_acc = in_acc && !in_i.end_of_text;
  assign term_acc = in_acc && in_i.end_of_text;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_set_q  <= FontSizeReset;
      size_file_q <= FontSizeReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.addr)
        CfgFontSizeSet:    size_set_q  <= cfg_i.data;
        CfgFontSizeInFile: size_file_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // structure check and counting for one byte
  logic [ByteW-1:0] b;
  logic [PendW-1:0] lead_len;
  logic             lead_bad;
  assign b = in_i.text_byte;

  always_comb begin
    lead_bad = 1'b0;
    lead_len = '0;
    priority if (b[7] == 1'b0)          lead_len = 3'd0;
    else if (b[7:5] == 3'b110)          lead_len = 3'd1;
    else if (b[7:4] == 4'b1110)         lead_len = 3'd2;
    else if (b[7:3] == 5'b11110)        lead_len = 3'd3;
    else if (b[7:2] == 6'b111110)       lead_len = 3'd4;
    else if (b[7:1] == 7'b1111110)      lead_len = 3'd5;
    else                                lead_bad = 1'b1;
  end

  always_comb begin
    pend_d  = pend_q;
    bad_d   = bad_q;
    glyph_d = glyph_q;
    raw_d   = raw_q;
    sat_d   = sat_q;
    if (term_acc) begin
      pend_d  = '0;
      bad_d   = 1'b0;
      glyph_d = '0;
      raw_d   = '0;
      sat_d   = 1'b0;
    end else if (byte_acc) begin
      // continuation tracking
      if (pend_q != '0) begin
        if (b[7:6] == 2'b10) begin
          pend_d = pend_q - 3'd1;
        end else begin
          bad_d  = 1'b1;
          pend_d = '0;
        end
      end else begin
        pend_d = lead_len;
        if (lead_bad) begin
          bad_d = 1'b1;
        end
      end
      // counters saturate at the byte limit
      if (raw_q >= MaxCount) begin
        sat_d = 1'b1;
      end else begin
        raw_d = raw_q + RawW'(1);
        if (b[7:6] == 2'b11) begin
          glyph_d = glyph_q + GlyphW'(2);
        end else if (b[7] == 1'b0) begin
          glyph_d = glyph_q + GlyphW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      bad_q   <= 1'b0;
      glyph_q <= '0;
      raw_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      bad_q   <= bad_d;
      glyph_q <= glyph_d;
      raw_q   <= raw_d;
      sat_q   <= sat_d;
    end
  end

  // result: height, half height toward zero, width product
  logic                      utf8_ok;
  logic signed [HeightW-1:0] height, half;
  logic [GlyphW-1:0]         cnt;
  logic [ProdW-1:0]          half_x, cnt_x, prod;

  assign utf8_ok = !bad_q && (pend_q == '0);
  assign height  = $signed({2'b00, size_set_q} + {2'b00, size_file_q} - HeightOffset);
  assign half    = (height + $signed({{(HeightW-1){1'b0}}, height[HeightW-1]})) >>> 1;
  assign cnt     = utf8_ok ? glyph_q : GlyphW'(raw_q);
  assign half_x  = {{(ProdW-HeightW){half[HeightW-1]}}, half};
  assign cnt_x   = {{(ProdW-GlyphW){1'b0}}, cnt};
  assign prod    = half_x * cnt_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (term_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (term_acc) begin
      res_utf8_q   <= utf8_ok;
      res_width_q  <= $signed(prod[WidthW-1:0]);
      res_height_q <= height;
      res_long_q   <= sat_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.valid_utf8   = res_utf8_q;
  assign out_o.pixel_width  = res_width_q;
  assign out_o.pixel_height = res_height_q;
  assign out_o.too_long     = res_long_q;

`ifndef NO_ASSERTIONS
  // byte count never runs past the limit
  a_raw_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_q <= MaxCount) else $error("byte count above limit");

  // saturation only once the count is full
  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (raw_q == MaxCount)) else $error("saturated below limit");

  // a terminator leaves every string counter cleared
  a_term_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_acc |=> (pend_q == '0 && !bad_q && raw_q == '0 && glyph_q == '0 && !sat_q))
    else $error("state not cleared after terminator");

  // width count is at most two per counted byte
  a_glyph_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, glyph_q} <= {GlyphW'(raw_q), 1'b0}) else $error("width count too large");
`endif

endmodule

`default_nettype wire

>>> test/tb_utf8_text_width_estimator.sv
// self-checking testbench for the utf-8 text width estimator
// needs u8tw_pkg, the three channel interfaces and the top level from rtl/core
`timescale 1ns / 1ps

module tb_utf8_text_width_estimator;
  import u8tw_pkg::*;

  localparam int unsigned MaxTextBytes = DefaultMaxTextBytes;
  localparam int          CycleLimit   = 600000;
  localparam int          DrainCycles  = 4;
  localparam int          TailCycles   = 8;
  localparam int          MaxReported  = 10;
  localparam int          PhaseBudget  = 180;
  localparam int          LongBytes    = 150;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [SizeW-1:0]   val;
  } size_write_t;

  typedef struct packed {
    logic                      valid_utf8;
    logic signed [WidthW-1:0]  pixel_width;
    logic signed [HeightW-1:0] pixel_height;
    logic                      too_long;
  } line_est_t;

  typedef enum int {LongAscii, LongPairs, LongNoise} long_fill_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  u8tw_in_if  in_if ();
  u8tw_cfg_if cfg_if ();
  u8tw_out_if out_if ();

  utf8_text_width_estimator #(
    .MAX_TEXT_BYTES(MaxTextBytes)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // stimulus queues and expected line estimates
  text_item_t  text_pending[$];
  size_write_t size_pending[$];
  line_est_t   estimate_q[$];

  int idle_pct = 28;
  int fail_count = 0;
  int cycle_cnt = 0;
  int queued_random = 0;

  // mirror of the font size registers
  logic [SizeW-1:0] font_set_q  = FontSizeReset;
  logic [SizeW-1:0] font_file_q = FontSizeReset;

  // mirror of the per-string state
  int pend_cnt  = 0;
  bit bad_seen  = 1'b0;
  int glyph_cnt = 0;
  int byte_cnt  = 0;
  bit sat_seen  = 1'b0;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // continuation bytes announced by a lead byte, -1 for a bad lead
  function automatic int lead_span(input logic [ByteW-1:0] b);
    casez (b)
      8'b0???????: return 0;
      8'b110?????: return 1;
      8'b1110????: return 2;
      8'b11110???: return 3;
      8'b111110??: return 4;
      8'b1111110?: return 5;
      default:     return -1;
    endcase
  endfunction

  // structure check and both counters for one text byte
  function automatic void track_byte(input logic [ByteW-1:0] b);
    int span;
    if (pend_cnt != 0) begin
      if (b[7:6] == 2'b10) begin
        pend_cnt--;
      end else begin
        bad_seen = 1'b1;
        pend_cnt = 0;
      end
    end else begin
      span = lead_span(b);
      if (span < 0) begin
        bad_seen = 1'b1;
        pend_cnt = 0;
      end else begin
        pend_cnt = span;
      end
    end
    if (byte_cnt >= MaxTextBytes) begin
      sat_seen = 1'b1;
    end else begin
      byte_cnt++;
      if (b >= 8'hC0) glyph_cnt += 2;
      else if (b < 8'h80) glyph_cnt += 1;
    end
  endfunction

  // line estimate at the terminator, then clear the string state
  function automatic line_est_t close_string();
    line_est_t est;
    int        height;
    int        half;
    longint    width;
    bit        ok;
    ok     = !bad_seen && (pend_cnt == 0);
    height = int'(font_set_q) + int'(font_file_q) - int'(HeightOffset);
    half   = height / 2;
    width  = longint'(half) * longint'(ok ? glyph_cnt : byte_cnt);
    est.valid_utf8   = ok;
    est.pixel_width  = width[WidthW-1:0];
    est.pixel_height = height[HeightW-1:0];
    est.too_long     = sat_seen;
    pend_cnt  = 0;
    bad_seen  = 1'b0;
    glyph_cnt = 0;
    byte_cnt  = 0;
    sat_seen  = 1'b0;
    return est;
  endfunction

  // text item driver
  always @(posedge clk_i or negedge rst_ni) begin : text_driver
    text_item_t nxt;
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.text_byte   <= '0;
      in_if.end_of_text <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (text_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = text_pending.pop_front();
        in_if.valid       <= 1'b1;
        in_if.text_byte   <= nxt.text_byte;
        in_if.end_of_text <= nxt.end_of_text;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk_i or negedge rst_ni) begin : size_driver
    size_write_t nxt;
    if (!rst_ni) begin
      cfg_if.valid <= 1'b0;
      cfg_if.addr  <= '0;
      cfg_if.data  <= '0;
    end else if (!cfg_if.valid || cfg_if.ready) begin
      if (size_pending.size() != 0) begin
        nxt = size_pending.pop_front();
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= nxt.idx;
        cfg_if.data  <= nxt.val;
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor: check results, follow register writes, predict on accepted items
  always @(posedge clk_i) begin : line_monitor
    line_est_t got;
    line_est_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.valid_utf8   = out_if.valid_utf8;
        got.pixel_width  = out_if.pixel_width;
        got.pixel_height = out_if.pixel_height;
        got.too_long     = out_if.too_long;
        if (estimate_q.size() == 0) begin
          if (fail_count < MaxReported)
            $display("unexpected result: valid_utf8 %0d width %0d height %0d too_long %0d",
                     got.valid_utf8, $signed(got.pixel_width), $signed(got.pixel_height),
                     got.too_long);
          fail_count++;
        end else begin
          want = estimate_q.pop_front();
          if (got.valid_utf8 !== want.valid_utf8 || got.pixel_width !== want.pixel_width ||
              got.pixel_height !== want.pixel_height || got.too_long !== want.too_long) begin
            if (fail_count < MaxReported) begin
              $display("mismatch: expected valid_utf8 %0d width %0d height %0d too_long %0d",
                       want.valid_utf8, $signed(want.pixel_width),
                       $signed(want.pixel_height), want.too_long);
              $display("          actual   valid_utf8 %0d width %0d height %0d too_long %0d",
                       got.valid_utf8, $signed(got.pixel_width),
                       $signed(got.pixel_height), got.too_long);
            end
            fail_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.addr == CfgFontSizeSet) font_set_q = cfg_if.data;
        else if (cfg_if.addr == CfgFontSizeInFile) font_file_q = cfg_if.data;
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.end_of_text) estimate_q.push_back(close_string());
        else track_byte(in_if.text_byte);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("utf8_text_width_estimator verification failed");
      $finish;
    end
  end

  task automatic push_text_byte(input logic [ByteW-1:0] b);
    text_pending.push_back('{text_byte: b, end_of_text: 1'b0});
  endtask

  // terminator carries a random don't-care byte
  task automatic push_terminator();
    text_pending.push_back('{text_byte: ByteW'($urandom_range(255)), end_of_text: 1'b1});
  endtask

  // one character: lead byte for the given span, then cont_n continuation bytes
  task automatic push_glyph(input int span, input int cont_n);
    logic [ByteW-1:0] lead;
    lead = ByteW'($urandom_range(255));
    case (span)
      0:       lead[7]   = 1'b0;
      1:       lead[7:5] = 3'b110;
      2:       lead[7:4] = 4'b1110;
      3:       lead[7:3] = 5'b11110;
      4:       lead[7:2] = 6'b111110;
      default: lead[7:1] = 7'b1111110;
    endcase
    push_text_byte(lead);
    for (int i = 0; i < cont_n; i++) push_text_byte({2'b10, 6'($urandom_range(63))});
  endtask

  function automatic int pick_span();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 60) return 1;
    if (r < 75) return 2;
    if (r < 87) return 3;
    if (r < 94) return 4;
    return 5;
  endfunction

  // mostly well-formed characters, some cut short, some raw noise
  task automatic push_random_string();
    int n_chars;
    int span;
    int r;
    int before_cnt;
    before_cnt = text_pending.size();
    n_chars = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    for (int c = 0; c < n_chars; c++) begin
      r = $urandom_range(99);
      if (r < 75) begin
        span = pick_span();
        push_glyph(span, span);
      end else if (r < 88) begin
        span = $urandom_range(1, 5);
        push_glyph(span, $urandom_range(0, span - 1));
      end else begin
        push_text_byte(ByteW'($urandom_range(255)));
      end
    end
    push_terminator();
    queued_random += text_pending.size() - before_cnt;
  endtask

  // long string of one kind of filler; an odd-length pair string ends in one ascii byte
  task automatic push_long_string(input int n_bytes, input long_fill_e fill);
    int left;
    left = n_bytes;
    while (left > 0) begin
      if (fill == LongPairs && left >= 2) begin
        push_glyph(1, 1);
        left -= 2;
      end else if (fill == LongNoise) begin
        push_text_byte(ByteW'($urandom_range(255)));
        left--;
      end else begin
        push_glyph(0, 0);
        left--;
      end
    end
    push_terminator();
  endtask

  // wait until every item is taken, every result checked, then idle for extra more clocks
  task automatic drain(input int extra);
    do @(negedge clk_i);
    while (text_pending.size() != 0 || in_if.valid || estimate_q.size() != 0 ||
           size_pending.size() != 0 || cfg_if.valid);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_sizes(input logic [SizeW-1:0] set_v, input logic [SizeW-1:0] file_v);
    size_pending.push_back('{idx: CfgFontSizeSet, val: set_v});
    size_pending.push_back('{idx: CfgFontSizeInFile, val: file_v});
    drain(1);
  endtask

  task automatic fill_random(input int budget);
    while (queued_random < budget) push_random_string();
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.text_byte   = '0;
    in_if.end_of_text = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.addr       = '0;
    cfg_if.data       = '0;
    out_if.ready      = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed strings at the reset font sizes
    // empty string
    push_terminator();
    // zero byte and top ascii byte
    push_text_byte(8'h00);
    push_text_byte(8'h7F);
    push_terminator();
    // two-byte character
    push_text_byte(8'hC2);
    push_text_byte(8'h80);
    push_terminator();
    // legacy six-byte character
    push_text_byte(8'hFD);
    for (int i = 0; i < 5; i++) push_text_byte(8'hBF);
    push_terminator();
    // bad leads: stray continuation, 0xff, 0xfe
    push_text_byte(8'h80);
    push_text_byte(8'hFF);
    push_text_byte(8'hFE);
    push_terminator();
    // zero byte where a continuation is due
    push_text_byte(8'hE0);
    push_text_byte(8'h00);
    push_text_byte(8'h41);
    push_terminator();
    // sequence cut short by the terminator
    push_text_byte(8'hF0);
    push_text_byte(8'h90);
    push_terminator();
    drain(DrainCycles);

    // largest sizes, long ascii string
    write_sizes(8'd255, 8'd255);
    fill_random(PhaseBudget);
    push_long_string(LongBytes, LongAscii);
    drain(DrainCycles);

    // zero sizes give the most negative height, long noise string
    write_sizes(8'd0, 8'd0);
    fill_random(2 * PhaseBudget);
    push_long_string(LongBytes, LongNoise);
    drain(DrainCycles);

    // smallest legal sizes, no idling, long two-byte strings of even and odd length
    idle_pct = 0;
    write_sizes(8'd1, 8'd1);
    push_long_string(LongBytes, LongPairs);
    push_long_string(LongBytes + 1, LongPairs);
    fill_random(3 * PhaseBudget);
    drain(DrainCycles);
    idle_pct = 28;

    // zero height
    write_sizes(8'd24, 8'd1);
    fill_random(4 * PhaseBudget);
    drain(DrainCycles);

    // height one, half height rounds to zero
    write_sizes(8'd26, 8'd0);
    fill_random(5 * PhaseBudget);
    drain(DrainCycles);

    // random sizes
    for (int p = 0; p < 2; p++) begin
      write_sizes(SizeW'($urandom_range(255)), SizeW'($urandom_range(255)));
      fill_random((6 + p) * PhaseBudget);
      drain(DrainCycles);
    end

    drain(TailCycles);
    if (fail_count == 0) begin
      $display("utf8_text_width_estimator verification clean");
    end else begin
      $display("utf8_text_width_estimator verification failed");
    end
    $finish;
  end

endmodule
